/* rtl/core/midi_event_command_decoder_assert.svh */
// assertion macros shared by the midi event command decoder modules
`ifndef MIDI_EVENT_COMMAND_DECODER_ASSERT_SVH
`define MIDI_EVENT_COMMAND_DECODER_ASSERT_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define MECD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MECD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MECD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MECD_ASSERT(label, prop, msg)
`define MECD_ASSERT_IMPL(label, ante, cons, msg)
`define MECD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/core/mecd_pkg.sv */
// shared types, codes and constants of the midi event command decoder
package mecd_pkg;

    // defaults for the top level parameters
    localparam int CHANNELS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    // field widths
    localparam int TPQ_BITS     = 15;
    localparam int SRATE_BITS   = 18;
    localparam int TEMPO_BITS   = 24;
    localparam int RATE_BITS    = 20;
    localparam int JUMP_BITS    = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 18;
    localparam int NUM_BITS     = TEMPO_BITS + SRATE_BITS;   // 42
    localparam int DEN_BITS     = 20 + TPQ_BITS;             // 35
    localparam int STEP_BITS    = $clog2(RATE_BITS);

    localparam logic [19:0]            US_PER_SEC   = 20'd1000000;
    localparam logic [RATE_BITS-1:0]   VALUE_MAX    = {RATE_BITS{1'b1}};
    localparam logic [TPQ_BITS-1:0]    TPQ_RESET    = 15'd24;
    localparam logic [SRATE_BITS-1:0]  SRATE_RESET  = 18'd48000;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TICKS_PER_QUARTER = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE       = 1'd1;

    // event kinds
    localparam logic [1:0] FUNC_CHANNEL = 2'd0;
    localparam logic [1:0] FUNC_TEMPO   = 2'd1;
    localparam logic [1:0] FUNC_TEXT    = 2'd2;

    // text marker codes
    localparam logic [1:0] MARK_LOOP_BEGIN = 2'd1;
    localparam logic [1:0] MARK_LOOP_END   = 2'd2;

    // status high nibble codes
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CONTROL  = 4'hB;
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    // controller numbers that map to commands
    localparam logic [6:0] CC_MOD       = 7'd1;
    localparam logic [6:0] CC_VOL       = 7'd7;
    localparam logic [6:0] CC_PAN       = 7'd10;
    localparam logic [6:0] CC_EXPR      = 7'd11;
    localparam logic [6:0] CC_LFO_SPEED = 7'd21;
    localparam logic [6:0] CC_MOD_TYPE  = 7'd22;
    localparam logic [6:0] CC_LFO_DELAY = 7'd26;

    typedef enum logic [3:0] {
        CMD_NOTE_OFF  = 4'd0,
        CMD_LFO_RESET = 4'd1,
        CMD_NOTE_ON   = 4'd2,
        CMD_MOD       = 4'd3,
        CMD_VOL       = 4'd4,
        CMD_PAN       = 4'd5,
        CMD_EXPR      = 4'd6,
        CMD_LFO_SPEED = 4'd7,
        CMD_MOD_TYPE  = 4'd8,
        CMD_LFO_DELAY = 4'd9,
        CMD_BEND      = 4'd10,
        CMD_TICK_RATE = 4'd11,
        CMD_LOOP_JUMP = 4'd12
    } cmd_t;

    // decoded operation handed from the front to the back
    typedef struct packed {
        cmd_t                  cmd;
        logic [3:0]            channel;
        logic [6:0]            key;
        logic [6:0]            velocity;
        logic [6:0]            program_res;
        logic [TEMPO_BITS-1:0] arg;       // value, or tempo for tick rate
        logic [JUMP_BITS-1:0]  jump_index;
        logic                  pair;      // lfo reset goes out first
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_CHK,
        B_DIV,
        B_FIRST,
        B_LAST
    } back_state_t;

endpackage

/* rtl/core/mecd_queue.sv */
// small fifo of decoded operations between front and back
module mecd_queue
    import mecd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic full,
    output logic empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    op_t                 mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

`include "midi_event_command_decoder_assert.svh"

    `MECD_ASSERT_IMPL(a_no_push_full, push, !full, "queue push while full")
    `MECD_ASSERT_IMPL(a_no_pop_empty, pop, !empty, "queue pop while empty")
    `MECD_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

/* rtl/core/mecd_front.sv */
// front end: accepts events, keeps program and loop state, classifies into operations
module mecd_front
    import mecd_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        q_full,
    output logic        push,
    output op_t         push_op
);

    localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    logic [6:0]            programs_reg [CHANNELS];
    logic                  loop_valid_reg;
    logic [INDEX_BITS-1:0] loop_start_reg;

    logic                  accept;
    logic [1:0]            func;
    logic [7:0]            status;
    logic [6:0]            data1;
    logic [6:0]            data2;
    logic [TEMPO_BITS-1:0] tempo_us;
    logic [1:0]            marker;
    logic [15:0]           event_index;
    logic [3:0]            kind;
    logic [3:0]            chan;
    logic                  chan_ok;
    logic [6:0]            chan_prog;
    logic                  prog_we;
    logic                  loop_set;
    logic [31:0]           index_wide;
    logic [31:0]           start_wide;

    // unpack the event
    assign func        = s_axis_tuser;
    assign status      = s_axis_tdata[7:0];
    assign data1       = s_axis_tdata[14:8];
    assign data2       = s_axis_tdata[21:15];
    assign tempo_us    = s_axis_tdata[45:22];
    assign marker      = s_axis_tdata[47:46];
    assign event_index = s_axis_tdata[63:48];
    assign kind        = status[7:4];
    assign chan        = status[3:0];

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // program lookup, channels past the store read as program zero
    assign chan_ok    = ({1'b0, chan} < CH_LIMIT);
    assign chan_prog  = chan_ok ? programs_reg[chan[CH_BITS-1:0]] : 7'd0;
    assign index_wide = {16'd0, event_index};
    assign start_wide = 32'(loop_start_reg);

    // classify the event
    always_comb
    begin
        push     = 1'b0;
        push_op  = '0;
        prog_we  = 1'b0;
        loop_set = 1'b0;
        push_op.channel = chan;
        case (func)
            FUNC_CHANNEL:
            begin
                case (kind)
                    KIND_NOTE_OFF:
                    begin
                        push        = accept;
                        push_op.cmd = CMD_NOTE_OFF;
                        push_op.key = data1;
                    end
                    KIND_NOTE_ON:
                    begin
                        push        = accept;
                        push_op.key = data1;
                        if (data2 == 7'd0)
                        begin
                            push_op.cmd = CMD_NOTE_OFF;
                        end
                        else
                        begin
                            push_op.cmd         = CMD_NOTE_ON;
                            push_op.velocity    = data2;
                            push_op.program_res = chan_prog;
                            push_op.pair        = 1'b1;
                        end
                    end
                    KIND_CONTROL:
                    begin
                        push        = accept;
                        push_op.arg = TEMPO_BITS'(data2);
                        case (data1)
                            CC_MOD:       push_op.cmd = CMD_MOD;
                            CC_VOL:       push_op.cmd = CMD_VOL;
                            CC_PAN:       push_op.cmd = CMD_PAN;
                            CC_EXPR:      push_op.cmd = CMD_EXPR;
                            CC_LFO_SPEED: push_op.cmd = CMD_LFO_SPEED;
                            CC_MOD_TYPE:  push_op.cmd = CMD_MOD_TYPE;
                            CC_LFO_DELAY: push_op.cmd = CMD_LFO_DELAY;
                            default:      push        = 1'b0;
                        endcase
                    end
                    KIND_PROGRAM:
                    begin
                        prog_we = accept && chan_ok;
                    end
                    KIND_BEND:
                    begin
                        push        = accept;
                        push_op.cmd = CMD_BEND;
                        push_op.arg = TEMPO_BITS'({data2, data1});
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
            FUNC_TEMPO:
            begin
                // zero results are dropped after the divide
                push            = accept;
                push_op.cmd     = CMD_TICK_RATE;
                push_op.channel = 4'd0;
                push_op.arg     = tempo_us;
            end
            FUNC_TEXT:
            begin
                push_op.channel = 4'd0;
                if (marker == MARK_LOOP_BEGIN)
                begin
                    loop_set = accept;
                end
                else if (marker == MARK_LOOP_END && loop_valid_reg)
                begin
                    push               = accept;
                    push_op.cmd        = CMD_LOOP_JUMP;
                    push_op.jump_index = start_wide[JUMP_BITS-1:0];
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // program store and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                programs_reg[i] <= 7'd0;
            end
            loop_valid_reg <= 1'b0;
            loop_start_reg <= '0;
        end
        else
        begin
            if (prog_we)
            begin
                programs_reg[chan[CH_BITS-1:0]] <= data1;
            end
            if (loop_set)
            begin
                loop_valid_reg <= 1'b1;
                loop_start_reg <= index_wide[INDEX_BITS-1:0];
            end
        end
    end

endmodule

/* rtl/core/mecd_back.sv */
// back end: tick rate divide and command output register
module mecd_back
    import mecd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [TPQ_BITS-1:0]   ticks_per_quarter,
    input  logic [SRATE_BITS-1:0] sample_rate,
    input  logic                  q_empty,
    input  op_t                   head_op,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,
    output logic [3:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    back_state_t           state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [NUM_BITS-1:0]   num_reg, num_next;
    logic [DEN_BITS-1:0]   den_reg, den_next;
    logic [DEN_BITS-1:0]   rem_reg, rem_next;
    logic [RATE_BITS-1:0]  quot_reg, quot_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [63:0]           out_data_reg, out_data_next;
    logic [3:0]            out_user_reg, out_user_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  load;
    logic [TPQ_BITS-1:0]   tpq_eff;
    logic                  saturate;
    logic [DEN_BITS:0]     trial;
    logic                  trial_ge;
    logic [RATE_BITS-1:0]  rate_value;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign tpq_eff  = (ticks_per_quarter == '0) ? TPQ_BITS'(1) : ticks_per_quarter;
    assign saturate = ({{RATE_BITS{1'b0}}, num_reg} >= {den_reg, {RATE_BITS{1'b0}}});
    assign trial    = {rem_reg, num_reg[RATE_BITS-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign rate_value = (op_reg.cmd == CMD_TICK_RATE) ? quot_reg : op_reg.arg[RATE_BITS-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head_op.cmd == CMD_TICK_RATE)
                    begin
                        state_next = B_MUL;
                    end
                    else if (head_op.pair)
                    begin
                        state_next = B_FIRST;
                    end
                    else
                    begin
                        state_next = B_LAST;
                    end
                end
            end
            B_MUL:
            begin
                state_next = B_CHK;
            end
            B_CHK:
            begin
                state_next = saturate ? B_LAST : B_DIV;
            end
            B_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ({quot_reg[RATE_BITS-2:0], trial_ge} == '0) ? B_IDLE : B_LAST;
                end
            end
            B_FIRST:
            begin
                if (out_free)
                begin
                    state_next = B_LAST;
                end
            end
            B_LAST:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and output register loads
    always_comb
    begin
        pop           = 1'b0;
        load          = 1'b0;
        op_next       = op_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        step_next     = step_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop     = 1'b1;
                    op_next = head_op;
                end
            end
            B_MUL:
            begin
                num_next = NUM_BITS'(op_reg.arg) * NUM_BITS'(sample_rate);
                den_next = DEN_BITS'(US_PER_SEC) * DEN_BITS'(tpq_eff);
            end
            B_CHK:
            begin
                // quotient would not fit, clamp; else divide the low bits
                if (saturate)
                begin
                    quot_next = VALUE_MAX;
                end
                else
                begin
                    rem_next  = DEN_BITS'(num_reg[NUM_BITS-1:RATE_BITS]);
                    quot_next = '0;
                    step_next = STEP_BITS'(RATE_BITS - 1);
                end
            end
            B_DIV:
            begin
                // one restoring step per cycle
                rem_next  = trial_ge ? DEN_BITS'(trial - {1'b0, den_reg}) : trial[DEN_BITS-1:0];
                quot_next = {quot_reg[RATE_BITS-2:0], trial_ge};
                num_next  = num_reg << 1;
                step_next = step_reg - 1'b1;
            end
            B_FIRST:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_user_next = CMD_LFO_RESET;
                    out_data_next = {60'd0, op_reg.channel};
                    out_last_next = 1'b0;
                end
            end
            B_LAST:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_user_next = op_reg.cmd;
                    out_data_next = {3'd0, op_reg.jump_index, rate_value,
                                     op_reg.program_res, op_reg.velocity,
                                     op_reg.key, op_reg.channel};
                    out_last_next = 1'b1;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        out_valid_next = load ? 1'b1 : (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

`include "midi_event_command_decoder_assert.svh"

    `MECD_ASSERT_IMPL(a_pop_in_idle, pop, state_reg == B_IDLE, "operation taken while busy")
    `MECD_ASSERT_IMPL(a_rem_below_den, state_reg == B_DIV, rem_reg < den_reg, "divider remainder out of range")
    `MECD_ASSERT_IMPL(a_load_when_free, load, out_free, "output register overwritten")
    `MECD_ASSERT_NEXT(a_first_then_last, state_reg == B_FIRST && out_free, state_reg == B_LAST, "note-on did not follow lfo reset")

endmodule

/* rtl/core/midi_event_command_decoder.sv */
// top level of the midi event command decoder
//
//  channel   dir  handshake               carries
//  s_axis    in   s_axis_tvalid/tready    one song event, kind in tuser
//  m_axis    out  m_axis_tvalid/tready    one synth command, cmd in tuser, tlast ends event
//  cfg       in   cfg_valid/cfg_ready     register write, index and data
//
// channel messages and loop jumps are registered in the queue, op_reg and out_data_reg
// tempo events use the 20-step restoring divider in the back end, skipped when saturated
// up to two decoded events wait in the queue while the back end is busy or stalled
// rst_n clears the program store, the loop state and the configuration to defaults
// cfg_ready is always high; writes belong between events, with nothing in flight
module midi_event_command_decoder
    import mecd_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // status, data1, data2, tempo_us, marker, event_index
    input  logic [63:0]              s_axis_tdata,
    // func
    input  logic [1:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // channel, key, velocity, program_res, value, jump_index, zero pad
    output logic [63:0]              m_axis_tdata,
    // cmd
    output logic [3:0]               m_axis_tuser,
    output logic                     m_axis_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [TPQ_BITS-1:0]   tpq_reg;
    logic [SRATE_BITS-1:0] srate_reg;
    logic                  q_full;
    logic                  q_empty;
    logic                  push;
    logic                  pop;
    op_t                   push_op;
    op_t                   head_op;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg   <= TPQ_RESET;
            srate_reg <= SRATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TICKS_PER_QUARTER: tpq_reg   <= cfg_data[TPQ_BITS-1:0];
                REG_SAMPLE_RATE:       srate_reg <= cfg_data[SRATE_BITS-1:0];
                default:               tpq_reg   <= tpq_reg;
            endcase
        end
    end

    // event decode and state
    mecd_front #(
        .CHANNELS   (CHANNELS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .push_op       (push_op)
    );

    // operation queue
    mecd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    // command generation
    mecd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .ticks_per_quarter (tpq_reg),
        .sample_rate       (srate_reg),
        .q_empty           (q_empty),
        .head_op           (head_op),
        .pop               (pop),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .m_axis_tlast      (m_axis_tlast)
    );

endmodule

/* tb/sv/tb_midi_event_command_decoder.sv */
// self-checking testbench of the midi event command decoder, directed table then random phases
module tb_midi_event_command_decoder;
    import mecd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 375;
    localparam int MAX_REPORTS  = 10;
    localparam int BY_MODEL     = -1;

    // codes the block treats as nothing to do
    localparam logic [1:0] FUNC_SPARE     = 2'd3;
    localparam logic [1:0] MARK_PLAIN     = 2'd0;
    localparam logic [1:0] MARK_SPARE     = 2'd3;
    localparam logic [3:0] KIND_TOUCH     = 4'hA;
    localparam logic [3:0] KIND_SYSTEM    = 4'hF;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [23:0] tempo_us;
        logic [1:0]  marker;
        logic [15:0] event_index;
    } song_event_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  channel;
        logic [6:0]  key;
        logic [6:0]  velocity;
        logic [6:0]  program_res;
        logic [19:0] value;
        logic [15:0] jump_index;
        logic        last;
    } synth_cmd_t;

    typedef struct {
        song_event_t ev;
        int          n_fixed;
        synth_cmd_t  fixed0;
        synth_cmd_t  fixed1;
    } table_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [63:0]              s_axis_tdata;
    logic [1:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [63:0]              m_axis_tdata;
    logic [3:0]               m_axis_tuser;
    logic                     m_axis_tlast;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // predictor state and configuration
    logic [6:0]            prog_store [16];
    logic                  loop_armed;
    logic [15:0]           loop_at;
    logic [TPQ_BITS-1:0]   tpq_cfg;
    logic [SRATE_BITS-1:0] srate_cfg;

    synth_cmd_t fresh_cmds[$];
    synth_cmd_t pending_cmds[$];
    table_row_t dir_rows[$];

    int  mismatches;
    int  cycle_count;
    int  idle_pct;
    int  stall_pct;
    int  hold_left;
    bit  hold_toggle;
    bit  hold_seen;

    midi_event_command_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic song_event_t ev_mk(logic [1:0] func, logic [7:0] status,
                                          logic [6:0] data1, logic [6:0] data2,
                                          logic [23:0] tempo_us, logic [1:0] marker,
                                          logic [15:0] event_index);
        song_event_t ev;
        ev.func        = func;
        ev.status      = status;
        ev.data1       = data1;
        ev.data2       = data2;
        ev.tempo_us    = tempo_us;
        ev.marker      = marker;
        ev.event_index = event_index;
        return ev;
    endfunction

    function automatic synth_cmd_t cmd_mk(cmd_t cmd, logic [3:0] channel, logic [6:0] key,
                                          logic [6:0] velocity, logic [6:0] program_res,
                                          logic [19:0] value, logic [15:0] jump_index,
                                          logic last);
        synth_cmd_t c;
        c.cmd         = cmd;
        c.channel     = channel;
        c.key         = key;
        c.velocity    = velocity;
        c.program_res = program_res;
        c.value       = value;
        c.jump_index  = jump_index;
        c.last        = last;
        return c;
    endfunction

    function automatic table_row_t row(song_event_t ev, int n_fixed,
                                       synth_cmd_t fixed0 = '0, synth_cmd_t fixed1 = '0);
        table_row_t r;
        r.ev      = ev;
        r.n_fixed = n_fixed;
        r.fixed0  = fixed0;
        r.fixed1  = fixed1;
        return r;
    endfunction

    // predictor: commands caused by one event, left in fresh_cmds
    function automatic void decode_event(song_event_t ev);
        logic [3:0]  kind;
        logic [3:0]  ch;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] spt;
        logic        mapped;
        synth_cmd_t  c;
        kind   = ev.status[7:4];
        ch     = ev.status[3:0];
        mapped = 1'b1;
        c      = '0;
        fresh_cmds.delete();
        case (ev.func)
            FUNC_CHANNEL:
            begin
                c.channel = ch;
                case (kind)
                    KIND_NOTE_OFF:
                    begin
                        c.cmd = CMD_NOTE_OFF;
                        c.key = ev.data1;
                        fresh_cmds.push_back(c);
                    end
                    KIND_NOTE_ON:
                    begin
                        if (ev.data2 == 7'd0)
                        begin
                            c.cmd = CMD_NOTE_OFF;
                            c.key = ev.data1;
                            fresh_cmds.push_back(c);
                        end
                        else
                        begin
                            c.cmd = CMD_LFO_RESET;
                            fresh_cmds.push_back(c);
                            c.cmd         = CMD_NOTE_ON;
                            c.key         = ev.data1;
                            c.velocity    = ev.data2;
                            c.program_res = prog_store[ch];
                            fresh_cmds.push_back(c);
                        end
                    end
                    KIND_PROGRAM:
                        prog_store[ch] = ev.data1;
                    KIND_CONTROL:
                    begin
                        case (ev.data1)
                            CC_MOD:       c.cmd = CMD_MOD;
                            CC_VOL:       c.cmd = CMD_VOL;
                            CC_PAN:       c.cmd = CMD_PAN;
                            CC_EXPR:      c.cmd = CMD_EXPR;
                            CC_LFO_SPEED: c.cmd = CMD_LFO_SPEED;
                            CC_MOD_TYPE:  c.cmd = CMD_MOD_TYPE;
                            CC_LFO_DELAY: c.cmd = CMD_LFO_DELAY;
                            default:      mapped = 1'b0;
                        endcase
                        if (mapped)
                        begin
                            c.value = 20'(ev.data2);
                            fresh_cmds.push_back(c);
                        end
                    end
                    KIND_BEND:
                    begin
                        c.cmd   = CMD_BEND;
                        c.value = 20'({ev.data2, ev.data1});
                        fresh_cmds.push_back(c);
                    end
                    default: ;
                endcase
            end
            FUNC_TEMPO:
            begin
                // exact integer tick rate, zero tick count acts as one
                num = 64'(ev.tempo_us) * 64'(srate_cfg);
                den = 64'(US_PER_SEC) * ((tpq_cfg == '0) ? 64'd1 : 64'(tpq_cfg));
                spt = num / den;
                if (spt > 64'(VALUE_MAX))
                    spt = 64'(VALUE_MAX);
                if (spt != 64'd0)
                begin
                    c.cmd   = CMD_TICK_RATE;
                    c.value = spt[19:0];
                    fresh_cmds.push_back(c);
                end
            end
            FUNC_TEXT:
            begin
                if (ev.marker == MARK_LOOP_BEGIN)
                begin
                    loop_armed = 1'b1;
                    loop_at    = ev.event_index;
                end
                else if (ev.marker == MARK_LOOP_END && loop_armed)
                begin
                    c.cmd        = CMD_LOOP_JUMP;
                    c.jump_index = loop_at;
                    fresh_cmds.push_back(c);
                end
            end
            default: ;
        endcase
        if (fresh_cmds.size() != 0)
            fresh_cmds[fresh_cmds.size()-1].last = 1'b1;
    endfunction

    // random event, mostly meaningful messages with random content
    function automatic song_event_t rand_event();
        song_event_t ev;
        int          sel;
        int          pick;
        ev  = ev_mk(2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
                    24'($urandom), 2'($urandom), 16'($urandom));
        sel = $urandom_range(99);
        if (sel < 68)
        begin
            ev.func = FUNC_CHANNEL;
            pick    = $urandom_range(9);
            case (pick)
                0, 1: ev.status[7:4] = KIND_NOTE_ON;
                2:    ev.status[7:4] = KIND_NOTE_OFF;
                3:    ev.status[7:4] = KIND_PROGRAM;
                4, 5: ev.status[7:4] = KIND_CONTROL;
                6:    ev.status[7:4] = KIND_BEND;
                7:
                begin
                    ev.status[7:4] = KIND_NOTE_ON;
                    ev.data2       = 7'd0;
                end
                default: ;
            endcase
            if (ev.status[7:4] == KIND_CONTROL && $urandom_range(3) != 0)
            begin
                case ($urandom_range(6))
                    0:       ev.data1 = CC_MOD;
                    1:       ev.data1 = CC_VOL;
                    2:       ev.data1 = CC_PAN;
                    3:       ev.data1 = CC_EXPR;
                    4:       ev.data1 = CC_LFO_SPEED;
                    5:       ev.data1 = CC_MOD_TYPE;
                    default: ev.data1 = CC_LFO_DELAY;
                endcase
            end
        end
        else if (sel < 83)
        begin
            ev.func = FUNC_TEMPO;
            if ($urandom_range(1) == 0)
                ev.tempo_us = 24'($urandom_range(2_000_000));
        end
        else if (sel < 97)
        begin
            ev.func = FUNC_TEXT;
            pick    = $urandom_range(19);
            if (pick < 8)
                ev.marker = MARK_LOOP_BEGIN;
            else if (pick < 17)
                ev.marker = MARK_LOOP_END;
            else
                ev.marker = (pick == 17) ? MARK_PLAIN : MARK_SPARE;
        end
        else
        begin
            ev.func = FUNC_SPARE;
        end
        return ev;
    endfunction

    // offer one event until it is taken, with random gaps before it
    task automatic push_event(song_event_t ev);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev.event_index, ev.marker, ev.tempo_us, ev.data2, ev.data1, ev.status};
        s_axis_tuser  <= ev.func;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // write both rate registers back to back
    task automatic set_rates(logic [TPQ_BITS-1:0] tpq, logic [SRATE_BITS-1:0] srate);
        bit taken;
        for (int i = 0; i < 2; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? REG_TICKS_PER_QUARTER : REG_SAMPLE_RATE;
            cfg_data  <= (i == 0) ? CFG_DATA_BITS'(tpq) : srate;
            do
            begin
                @(negedge clk);
                taken = cfg_ready;
                @(posedge clk);
            end
            while (!taken);
        end
        cfg_valid <= 1'b0;
        tpq_cfg   = tpq;
        srate_cfg = srate;
    endtask

    // stop offering and wait until every expected command has come out,
    // then long enough for queued tempo events with no command to finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(logic [TPQ_BITS-1:0] tpq, logic [SRATE_BITS-1:0] srate,
                                int idle, int stall, bit hold);
        song_event_t ev;
        idle_pct  = idle;
        stall_pct <= stall;
        set_rates(tpq, srate);
        if (hold)
            hold_toggle <= ~hold_toggle;
        repeat (PHASE_ITEMS)
        begin
            ev = rand_event();
            push_event(ev);
            decode_event(ev);
            foreach (fresh_cmds[k])
                pending_cmds.push_back(fresh_cmds[k]);
        end
        drain();
    endtask

    // output checker: compare each command transaction with the oldest expectation
    always @(negedge clk)
    begin
        synth_cmd_t got;
        synth_cmd_t want;
        bit         bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.cmd         = cmd_t'(m_axis_tuser);
            got.channel     = m_axis_tdata[3:0];
            got.key         = m_axis_tdata[10:4];
            got.velocity    = m_axis_tdata[17:11];
            got.program_res = m_axis_tdata[24:18];
            got.value       = m_axis_tdata[44:25];
            got.jump_index  = m_axis_tdata[60:45];
            got.last        = m_axis_tlast;
            if (pending_cmds.size() == 0)
            begin
                want = '0;
                bad  = 1'b1;
            end
            else
            begin
                want = pending_cmds.pop_front();
                bad  = (got.cmd !== want.cmd) || (got.channel !== want.channel)
                    || (got.key !== want.key) || (got.velocity !== want.velocity)
                    || (got.program_res !== want.program_res)
                    || (got.value !== want.value) || (got.jump_index !== want.jump_index)
                    || (got.last !== want.last);
            end
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: command mismatch, %0d pending before it\n", $realtime,
                        pending_cmds.size(),
                        "  expected cmd %0d ch %0d key %0d vel %0d", want.cmd, want.channel,
                        want.key, want.velocity,
                        " prog %0d val %0d jump %0d last %0d\n", want.program_res,
                        want.value, want.jump_index, want.last,
                        "  actual   cmd %0d ch %0d key %0d vel %0d", got.cmd, got.channel,
                        got.key, got.velocity,
                        " prog %0d val %0d jump %0d last %0d", got.program_res,
                        got.value, got.jump_index, got.last);
            end
        end
    end

    // stimulus
    initial
    begin
        table_row_t r;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_left   = 0;
        tpq_cfg     = TPQ_RESET;
        srate_cfg   = SRATE_RESET;
        loop_armed  = 1'b0;
        loop_at     = '0;
        foreach (prog_store[c])
            prog_store[c] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings; fixed rows hold hand-typed expected commands
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_NOTE_ON, 4'd0}, 60, 100, 0, 0, 0), 2,
            cmd_mk(CMD_LFO_RESET, 0, 0, 0, 0, 0, 0, 0),
            cmd_mk(CMD_NOTE_ON, 0, 60, 100, 0, 0, 0, 1)));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_NOTE_ON, 4'd15}, 127, 0, 0, 0, 0), 1,
            cmd_mk(CMD_NOTE_OFF, 15, 127, 0, 0, 0, 0, 1)));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_NOTE_OFF, 4'd0}, 0, 127, 0, 0, 0), 1,
            cmd_mk(CMD_NOTE_OFF, 0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_PROGRAM, 4'd5}, 127, 0, 0, 0, 0), 0));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_NOTE_ON, 4'd5}, 1, 127, 0, 0, 0),
            BY_MODEL));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_PROGRAM, 4'd15}, 85, 3, 0, 0, 0), 0));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_NOTE_ON, 4'd15}, 64, 1, 0, 0, 0),
            BY_MODEL));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd0}, CC_MOD, 127, 0, 0, 0),
            1, cmd_mk(CMD_MOD, 0, 0, 0, 0, 127, 0, 1)));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd7}, CC_VOL, 0, 0, 0, 0),
            BY_MODEL));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd10}, CC_PAN, 64, 0, 0, 0),
            BY_MODEL));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd11}, CC_EXPR, 127, 0, 0, 0),
            BY_MODEL));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd12}, CC_LFO_SPEED, 1, 0,
            0, 0), BY_MODEL));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd13}, CC_MOD_TYPE, 99, 0,
            0, 0), BY_MODEL));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd14}, CC_LFO_DELAY, 127, 0,
            0, 0), BY_MODEL));
        // unmapped controller number
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_CONTROL, 4'd15}, 127, 127, 0, 0, 0), 0));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_BEND, 4'd3}, 127, 127, 0, 0, 0), 1,
            cmd_mk(CMD_BEND, 3, 0, 0, 0, 16383, 0, 1)));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_BEND, 4'd0}, 0, 0, 0, 0, 0), BY_MODEL));
        // aftertouch and system messages do nothing
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_TOUCH, 4'd2}, 5, 6, 0, 0, 0), 0));
        dir_rows.push_back(row(ev_mk(FUNC_CHANNEL, {KIND_SYSTEM, 4'd15}, 127, 127, 0, 0, 0), 0));
        // 500000 us at 48 kHz and 24 ticks is 1000 samples per tick
        dir_rows.push_back(row(ev_mk(FUNC_TEMPO, 0, 0, 0, 500000, 0, 0), 1,
            cmd_mk(CMD_TICK_RATE, 0, 0, 0, 0, 1000, 0, 1)));
        dir_rows.push_back(row(ev_mk(FUNC_TEMPO, 0, 0, 0, 0, 0, 0), 0));
        dir_rows.push_back(row(ev_mk(FUNC_TEMPO, 0, 0, 0, 24'hFFFFFF, 0, 0), BY_MODEL));
        // loop end before any loop start, then a start and one jump
        dir_rows.push_back(row(ev_mk(FUNC_TEXT, 0, 0, 0, 0, MARK_LOOP_END, 16'd77), 0));
        dir_rows.push_back(row(ev_mk(FUNC_TEXT, 0, 0, 0, 0, MARK_LOOP_BEGIN, 16'hFFFF), 0));
        dir_rows.push_back(row(ev_mk(FUNC_TEXT, 0, 0, 0, 0, MARK_LOOP_END, 16'd3), 1,
            cmd_mk(CMD_LOOP_JUMP, 0, 0, 0, 0, 0, 16'hFFFF, 1)));
        dir_rows.push_back(row(ev_mk(FUNC_TEXT, 8'hFF, 0, 0, 0, MARK_SPARE, 16'd9), 0));
        dir_rows.push_back(row(ev_mk(FUNC_SPARE, {KIND_NOTE_ON, 4'd1}, 9, 9, 24'hFFFFFF,
            MARK_LOOP_END, 16'd1), 0));

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            push_event(r.ev);
            decode_event(r.ev);
            if (r.n_fixed == BY_MODEL)
            begin
                foreach (fresh_cmds[k])
                    pending_cmds.push_back(fresh_cmds[k]);
            end
            else
            begin
                if (r.n_fixed > 0)
                    pending_cmds.push_back(r.fixed0);
                if (r.n_fixed > 1)
                    pending_cmds.push_back(r.fixed1);
            end
        end
        drain();

        // random phases over rate settings, input idling and output stall patterns
        random_phase(15'd1, 18'd192000, 0, 0, 1'b0);
        random_phase(15'd0, 18'd8000, 57, 0, 1'b0);
        random_phase(15'd32767, 18'd8000, 0, 57, 1'b0);
        random_phase(15'd480, 18'd44100, 33, 33, 1'b0);
        random_phase(15'd96, 18'd96000, 0, 0, 1'b1);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* midi_event_command_decoder.f */
+incdir+rtl/core
rtl/core/mecd_pkg.sv
rtl/core/mecd_queue.sv
rtl/core/mecd_front.sv
rtl/core/mecd_back.sv
rtl/core/midi_event_command_decoder.sv
tb/sv/tb_midi_event_command_decoder.sv
